// ===== design/lbpm_pkg.sv =====
// Shared types, constants and register indexes of the light bar pair matcher.
`default_nettype none
package lbpm_pkg;

    localparam int MAX_LIGHTS = 32;
    localparam int MAX_PAIRS  = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_LIGHTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PAIR_W     = $clog2(MAX_PAIRS);
    localparam int PCNT_W     = PAIR_W + 1;
    localparam int S_DATA_W   = 136;
    localparam int M_DATA_W   = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_COLOR = 3'd0;
    localparam logic [2:0] CFG_MIN_RATIO    = 3'd1;
    localparam logic [2:0] CFG_MIN_SMALL    = 3'd2;
    localparam logic [2:0] CFG_MAX_SMALL    = 3'd3;
    localparam logic [2:0] CFG_MIN_LARGE    = 3'd4;
    localparam logic [2:0] CFG_MAX_LARGE    = 3'd5;
    localparam logic [2:0] CFG_MAX_TILT     = 3'd6;

    // distance threshold selectors
    localparam logic [1:0] THR_MIN_SMALL = 2'd0;
    localparam logic [1:0] THR_MAX_SMALL = 2'd1;
    localparam logic [1:0] THR_MIN_LARGE = 2'd2;
    localparam logic [1:0] THR_MAX_LARGE = 2'd3;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t      top_x;
        coord_t      top_y;
        coord_t      bottom_x;
        coord_t      bottom_y;
        coord_t      mid_x;
        coord_t      mid_y;
        coord_t      bar_length;
        coord_t      bar_width;
        logic [1:0]  bar_color;
    } light_t;

    typedef struct packed {
        logic        target_color;
        logic [7:0]  min_length_ratio;
        logic [11:0] min_small_distance;
        logic [11:0] max_small_distance;
        logic [11:0] min_large_distance;
        logic [11:0] max_large_distance;
        logic [15:0] max_tilt_tangent;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic ok;
        logic is_large;
    } metric_res_t;

    typedef enum logic [2:0] {
        M_IDLE, M_DIFF, M_SQ, M_THR_A, M_THR_SQ, M_THR_CMP, M_DONE
    } metric_state_t;

    typedef enum logic [3:0] {
        S_LOAD, S_RD_I, S_LAT_I, S_RD_J, S_LAT_J, S_METRIC,
        S_CK_RD, S_CK_CHK, S_E_RD, S_E_LD
    } scan_state_t;

endpackage
`default_nettype wire

// ===== design/lbpm_cfg.sv =====
// Configuration register file of the pair matcher.
`default_nettype none
module lbpm_cfg
    import lbpm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    // register writes, reset to default limits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_color       <= 1'b0;
            cfg_reg.min_length_ratio   <= 8'd179;
            cfg_reg.min_small_distance <= 12'd205;
            cfg_reg.max_small_distance <= 12'd819;
            cfg_reg.min_large_distance <= 12'd819;
            cfg_reg.max_large_distance <= 12'd1408;
            cfg_reg.max_tilt_tangent   <= 16'd179;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TARGET_COLOR: cfg_reg.target_color       <= cfg_wdata[0];
                CFG_MIN_RATIO:    cfg_reg.min_length_ratio   <= cfg_wdata[7:0];
                CFG_MIN_SMALL:    cfg_reg.min_small_distance <= cfg_wdata[11:0];
                CFG_MAX_SMALL:    cfg_reg.max_small_distance <= cfg_wdata[11:0];
                CFG_MIN_LARGE:    cfg_reg.min_large_distance <= cfg_wdata[11:0];
                CFG_MAX_LARGE:    cfg_reg.max_large_distance <= cfg_wdata[11:0];
                CFG_MAX_TILT:     cfg_reg.max_tilt_tangent   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== design/lbpm_metric.sv =====
// Pair geometry unit: length ratio, tilt and distance class, stepped by a state sequencer.
`default_nettype none
module lbpm_metric
    import lbpm_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   start,
    input  wire light_t li,
    input  wire light_t lj,
    input  wire cfg_t   cfg,
    output metric_res_t res
);

    metric_state_t state_reg, state_next;
    logic [1:0]  thr_reg, thr_next;
    logic [15:0] dx_reg, dy_reg, sh_reg, lg_reg;
    logic [16:0] lsum_reg;
    logic [31:0] dx2_reg, dy2_reg;
    logic        len_pass_reg, tilt_ok_reg;
    logic [50:0] bq_reg;
    logic [28:0] a_reg;
    logic [57:0] sq_reg;
    logic [3:0]  le_reg;
    logic        lt_minl_reg;
    logic [11:0] thr_val;
    logic [32:0] d2;

    // threshold selection
    always_comb begin
        unique case (thr_reg)
            THR_MIN_SMALL: thr_val = cfg.min_small_distance;
            THR_MAX_SMALL: thr_val = cfg.max_small_distance;
            THR_MIN_LARGE: thr_val = cfg.min_large_distance;
            THR_MAX_LARGE: thr_val = cfg.max_large_distance;
            default:       thr_val = cfg.min_small_distance;
        endcase
    end

    assign d2 = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    // sequencer
    always_comb begin
        state_next = state_reg;
        thr_next   = thr_reg;
        unique case (state_reg)
            M_IDLE:    if (start) state_next = M_DIFF;
            M_DIFF:    state_next = M_SQ;
            M_SQ:      begin
                state_next = M_THR_A;
                thr_next   = THR_MIN_SMALL;
            end
            M_THR_A:   state_next = M_THR_SQ;
            M_THR_SQ:  state_next = M_THR_CMP;
            M_THR_CMP: begin
                thr_next = thr_reg + 2'd1;
                state_next = (thr_reg == THR_MAX_LARGE) ? M_DONE : M_THR_A;
            end
            M_DONE:    state_next = M_IDLE;
            default:   state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            thr_reg   <= THR_MIN_SMALL;
        end else begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
        end
    end

    // datapath, the products of each state registered in that state
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            M_DIFF: begin
                dx_reg   <= (li.mid_x > lj.mid_x) ? li.mid_x - lj.mid_x : lj.mid_x - li.mid_x;
                dy_reg   <= (li.mid_y > lj.mid_y) ? li.mid_y - lj.mid_y : lj.mid_y - li.mid_y;
                sh_reg   <= (li.bar_length < lj.bar_length) ? li.bar_length : lj.bar_length;
                lg_reg   <= (li.bar_length < lj.bar_length) ? lj.bar_length : li.bar_length;
                lsum_reg <= {1'b0, li.bar_length} + {1'b0, lj.bar_length};
            end
            M_SQ: begin
                dx2_reg      <= dx_reg * dx_reg;
                dy2_reg      <= dy_reg * dy_reg;
                len_pass_reg <= {sh_reg, 8'd0} > (cfg.min_length_ratio * lg_reg);
                tilt_ok_reg  <= {8'd0, dy_reg, 8'd0} < (cfg.max_tilt_tangent * dx_reg);
            end
            M_THR_A: begin
                bq_reg <= {d2, 18'd0};
                a_reg  <= thr_val * lsum_reg;
            end
            M_THR_SQ: sq_reg <= a_reg * a_reg;
            M_THR_CMP: begin
                le_reg[thr_reg] <= sq_reg <= {7'd0, bq_reg};
                if (thr_reg == THR_MIN_LARGE) lt_minl_reg <= sq_reg < {7'd0, bq_reg};
            end
            default: ;
        endcase
    end

    // verdict: min <= d < max for either class
    assign res.done     = (state_reg == M_DONE);
    assign res.ok       = len_pass_reg && tilt_ok_reg &&
                          ((le_reg[THR_MIN_SMALL] && !le_reg[THR_MAX_SMALL]) ||
                           (le_reg[THR_MIN_LARGE] && !le_reg[THR_MAX_LARGE]));
    assign res.is_large = lt_minl_reg;

endmodule
`default_nettype wire

// ===== design/light_bar_pair_matcher_core.sv =====
// Top level: light store, pair scan sequencer, result store and output register.
// Load: one light per cycle; a frame's last light starts the scan.
// Scan: each left light is read, then each right candidate, then the geometry unit
// runs; for an accepted pair the containment check walks the lights between the two
// (one light store read port) and then closes it. Results then leave in order.
// Reset (aresetn low, synchronous) empties the frame and restores default limits.
`default_nettype none
module light_bar_pair_matcher_core
    import lbpm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // top_x, top_y, bottom_x, bottom_y, mid_x, mid_y, bar_length, bar_width,
    // bar_color, zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // left_index, right_index, is_large, overflowed, zero pad
    output logic [M_DATA_W-1:0]      m_tdata,
    // pair_valid
    output logic                     m_tuser,
    output logic                     m_tlast,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_addr,
    input  wire logic [15:0]         cfg_wdata
);

    cfg_t        cfg;
    metric_res_t mres;

    scan_state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              lost_reg, lost_next;
    logic              over_reg, over_next;
    logic [CNT_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [PCNT_W-1:0] n_reg, n_next, r_reg, r_next;
    light_t            li_reg, lj_reg;
    light_t            light_mem [MAX_LIGHTS];
    light_t            rdata_reg, in_light;
    logic [IDX_W-1:0]  raddr;
    logic              lwe;
    logic [2*IDX_W:0]  res_mem [MAX_PAIRS];
    logic [2*IDX_W:0]  res_rdata_reg;
    logic              rwe;
    logic              metric_start;
    logic              s_acc, out_free;
    logic              out_load;
    logic              out_pv, out_last;
    logic [2*IDX_W:0]  out_pair;
    logic              m_valid_reg, m_pv_reg, m_last_reg, m_over_reg;
    logic [2*IDX_W:0]  m_pair_reg;
    logic [15:0]       b0_reg, b2_reg;
    logic [16:0]       b1_reg, b3_reg, lsum_reg, wsum_reg;
    logic [15:0]       mnx, mxx, mny, mxy;
    logic              hit;

    lbpm_cfg u_cfg (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata, .cfg
    );

    lbpm_metric u_metric (
        .aclk, .aresetn, .start(metric_start), .li(li_reg), .lj(lj_reg), .cfg, .res(mres)
    );

    assign in_light = '{top_x: s_tdata[15:0], top_y: s_tdata[31:16],
                        bottom_x: s_tdata[47:32], bottom_y: s_tdata[63:48],
                        mid_x: s_tdata[79:64], mid_y: s_tdata[95:80],
                        bar_length: s_tdata[111:96], bar_width: s_tdata[127:112],
                        bar_color: s_tdata[129:128]};

    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign lwe      = s_acc && (count_reg < CNT_W'(MAX_LIGHTS));

    // light store
    always_ff @(posedge aclk) begin
        if (lwe) light_mem[count_reg[IDX_W-1:0]] <= in_light;
        rdata_reg <= light_mem[raddr];
    end

    // result store
    always_ff @(posedge aclk) begin
        if (rwe) res_mem[n_reg[PAIR_W-1:0]] <= {i_reg[IDX_W-1:0], j_reg[IDX_W-1:0],
                                                mres.is_large};
        res_rdata_reg <= res_mem[r_reg[PAIR_W-1:0]];
    end

    // bounding box of the pair in whole pixels
    always_comb begin
        mnx = li_reg.top_x;  mxx = li_reg.top_x;
        mny = li_reg.top_y;  mxy = li_reg.top_y;
        if (li_reg.bottom_x < mnx) mnx = li_reg.bottom_x;
        if (li_reg.bottom_x > mxx) mxx = li_reg.bottom_x;
        if (lj_reg.top_x < mnx) mnx = lj_reg.top_x;
        if (lj_reg.top_x > mxx) mxx = lj_reg.top_x;
        if (lj_reg.bottom_x < mnx) mnx = lj_reg.bottom_x;
        if (lj_reg.bottom_x > mxx) mxx = lj_reg.bottom_x;
        if (li_reg.bottom_y < mny) mny = li_reg.bottom_y;
        if (li_reg.bottom_y > mxy) mxy = li_reg.bottom_y;
        if (lj_reg.top_y < mny) mny = lj_reg.top_y;
        if (lj_reg.top_y > mxy) mxy = lj_reg.top_y;
        if (lj_reg.bottom_y < mny) mny = lj_reg.bottom_y;
        if (lj_reg.bottom_y > mxy) mxy = lj_reg.bottom_y;
    end

    always_ff @(posedge aclk) begin
        b0_reg   <= {mnx[15:4], 4'd0};
        b1_reg   <= {{1'b0, mxx[15:4]} + 13'd1, 4'd0};
        b2_reg   <= {mny[15:4], 4'd0};
        b3_reg   <= {{1'b0, mxy[15:4]} + 13'd1, 4'd0};
        lsum_reg <= {1'b0, li_reg.bar_length} + {1'b0, lj_reg.bar_length};
        wsum_reg <= {1'b0, li_reg.bar_width} + {1'b0, lj_reg.bar_width};
    end

    // light between the pair that blocks it
    function automatic logic in_box(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] bx0, input logic [16:0] bx1,
                                    input logic [15:0] by0, input logic [16:0] by1);
        in_box = (x >= bx0) && ({1'b0, x} < bx1) && (y >= by0) && ({1'b0, y} < by1);
    endfunction

    assign hit = ({1'b0, rdata_reg.bar_width} <= wsum_reg) &&
                 ({rdata_reg.bar_length, 2'd0} >= {1'b0, lsum_reg}) &&
                 (in_box(rdata_reg.top_x, rdata_reg.top_y, b0_reg, b1_reg, b2_reg, b3_reg) ||
                  in_box(rdata_reg.bottom_x, rdata_reg.bottom_y, b0_reg, b1_reg, b2_reg,
                         b3_reg) ||
                  in_box(rdata_reg.mid_x, rdata_reg.mid_y, b0_reg, b1_reg, b2_reg, b3_reg));

    // scan sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        lost_next    = lost_reg;
        over_next    = over_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        raddr        = '0;
        rwe          = 1'b0;
        metric_start = 1'b0;
        out_load     = 1'b0;
        out_pv       = 1'b0;
        out_last     = 1'b0;
        out_pair     = '0;
        unique case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    if (lwe) count_next = count_reg + CNT_W'(1);
                    else     lost_next  = 1'b1;
                    if (s_tlast) begin
                        over_next  = lost_reg || !lwe;
                        i_next     = '0;
                        n_next     = '0;
                        state_next = S_RD_I;
                    end
                end
            end
            S_RD_I: begin
                raddr = i_reg[IDX_W-1:0];
                if (i_reg >= count_reg) begin
                    r_next     = '0;
                    state_next = S_E_RD;
                end else begin
                    state_next = S_LAT_I;
                end
            end
            S_LAT_I: begin
                if (rdata_reg.bar_color != {1'b0, cfg.target_color}) begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RD_I;
                end else begin
                    j_next     = i_reg + CNT_W'(1);
                    state_next = S_RD_J;
                end
            end
            S_RD_J: begin
                raddr = j_reg[IDX_W-1:0];
                if (j_reg >= count_reg) begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RD_I;
                end else begin
                    state_next = S_LAT_J;
                end
            end
            S_LAT_J: begin
                if (rdata_reg.bar_color != {1'b0, cfg.target_color}) begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_RD_J;
                end else begin
                    metric_start = 1'b1;
                    state_next   = S_METRIC;
                end
            end
            S_METRIC: begin
                if (mres.done) begin
                    if (mres.ok) begin
                        k_next     = i_reg + CNT_W'(1);
                        state_next = S_CK_RD;
                    end else begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_RD_J;
                    end
                end
            end
            S_CK_RD: begin
                raddr = k_reg[IDX_W-1:0];
                if (k_reg >= j_reg) begin
                    // pair survives the walk
                    if (n_reg < PCNT_W'(MAX_PAIRS)) begin
                        rwe    = 1'b1;
                        n_next = n_reg + PCNT_W'(1);
                    end else begin
                        over_next = 1'b1;
                    end
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_RD_J;
                end else begin
                    state_next = S_CK_CHK;
                end
            end
            S_CK_CHK: begin
                if (hit) begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_RD_J;
                end else begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_CK_RD;
                end
            end
            S_E_RD: begin
                if (out_free) begin
                    if (n_reg == '0) begin
                        // empty frame marker
                        out_load   = 1'b1;
                        out_last   = 1'b1;
                        count_next = '0;
                        lost_next  = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_E_LD;
                    end
                end
            end
            S_E_LD: begin
                out_load = 1'b1;
                out_pv   = 1'b1;
                out_pair = res_rdata_reg;
                out_last = (r_reg + PCNT_W'(1) == n_reg);
                r_next   = r_reg + PCNT_W'(1);
                if (out_last) begin
                    count_next = '0;
                    lost_next  = 1'b0;
                    state_next = S_LOAD;
                end else begin
                    state_next = S_E_RD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            lost_reg  <= 1'b0;
            over_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            r_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            lost_reg  <= lost_next;
            over_reg  <= over_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            r_reg     <= r_next;
        end
    end

    // latched pair operands
    always_ff @(posedge aclk) begin
        if (state_reg == S_LAT_I) li_reg <= rdata_reg;
        if (state_reg == S_LAT_J) lj_reg <= rdata_reg;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pv_reg   <= out_pv;
            m_pair_reg <= out_pair;
            m_over_reg <= over_reg;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_pv_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_over_reg, m_pair_reg[0],
                       m_pair_reg[IDX_W:1], m_pair_reg[2*IDX_W:IDX_W+1]};

endmodule
`default_nettype wire

// ===== design/lbpm_checker.sv =====
// Port-level checks of the pair matcher, bound to the top level.
`default_nettype none
module lbpm_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // a held result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // empty-frame marker closes its frame
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty marker without frame end");

    // left light loaded before right light
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[4:0] < m_tdata[9:5])
        else $error("pair indexes out of order");

endmodule

bind light_bar_pair_matcher_core lbpm_props u_lbpm_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
`default_nettype wire
